FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/spd_pkg.sv
// Types and constants of the SYN port-scan detector.
package spd_pkg;

  localparam logic [31:0] HASH_MULT    = 32'd2654435761;
  localparam int          SYN_BIT      = 1;
  localparam logic [15:0] THRESH_RESET = 16'd20;
  localparam logic [31:0] WINDOW_RESET = 32'd5000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam int          CFG_IDX_W      = 2;
  localparam logic [1:0]  CFG_IDX_THRESH = 2'd0;
  localparam logic [1:0]  CFG_IDX_WINDOW = 2'd1;

  typedef struct packed {
    logic        is_ipv4;
    logic        is_tcp;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [63:0] time_ms;
  } spd_hdr_t;

  typedef struct packed {
    logic        alert_fired;
    logic [31:0] alert_src_addr;
    logic [31:0] alert_dst_addr;
    logic [15:0] alert_src_port;
    logic [15:0] alert_dst_port;
    logic [63:0] alert_time_ms;
  } spd_alert_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] source;
    logic [15:0] port_count;
    logic [15:0] prev_port;
    logic [63:0] window_start;
  } spd_entry_t;

  localparam int ENTRY_W = $bits(spd_entry_t);

  typedef struct packed {
    logic load_in;
    logic hash;
    logic eval;
    logic update;
    logic commit;
    logic clear_wr;
  } spd_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } spd_sts_t;

endpackage

FILE: hw/rtl/spd_ifs.sv
// Handshake interfaces for the header, alert and configuration channels.
interface spd_pkt_if;
  logic        valid;
  logic        ready;
  logic        is_ipv4;
  logic        is_tcp;
  logic [7:0]  tcp_flag_bits;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [63:0] time_ms;

  modport source (output valid, is_ipv4, is_tcp, tcp_flag_bits, source_addr, dest_addr,
                  source_port, dest_port, time_ms, input ready);
  modport sink (input valid, is_ipv4, is_tcp, tcp_flag_bits, source_addr, dest_addr,
                source_port, dest_port, time_ms, output ready);
endinterface

interface spd_alert_if;
  logic        valid;
  logic        ready;
  logic        alert_fired;
  logic [31:0] alert_src_addr;
  logic [31:0] alert_dst_addr;
  logic [15:0] alert_src_port;
  logic [15:0] alert_dst_port;
  logic [63:0] alert_time_ms;

  modport source (output valid, alert_fired, alert_src_addr, alert_dst_addr, alert_src_port,
                  alert_dst_port, alert_time_ms, input ready);
  modport sink (input valid, alert_fired, alert_src_addr, alert_dst_addr, alert_src_port,
                alert_dst_port, alert_time_ms, output ready);
endinterface

interface spd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/spd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/spd_ctrl.sv
// Sequencer for the table clear pass and the per-beat read-modify-write.
module spd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  spd_pkg::spd_sts_t sts,
  output spd_pkg::spd_cmd_t cmd
);
  import spd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = accept;
    cmd.hash     = (state == S_HASH);
    cmd.eval     = (state == S_EVAL);
    cmd.update   = (state == S_UPDATE);
    cmd.commit   = (state == S_DONE) && sts.out_free;
    cmd.clear_wr = (state == S_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (sts.clear_done) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state    <= S_HASH;
            in_ready <= 1'b0;
          end
        end
        S_HASH:   state <= S_READ;
        S_READ:   state <= S_EVAL;
        S_EVAL:   state <= S_UPDATE;
        S_UPDATE: state <= S_DONE;
        S_DONE: begin
          if (sts.out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_no_accept_in_clear, (state == S_CLEAR) |-> !in_ready, "ready during clear pass")
  `ASSERT_CLK(a_single_commit, cmd.commit |=> !cmd.commit && !cmd.hash, "commit repeated")
  `ASSERT_CLK(a_ready_idle, in_ready |-> (state == S_IDLE), "ready outside idle")
endmodule

FILE: hw/rtl/spd_datapath.sv
// Hash, slot table, window and port-count update, config registers and result register.
module spd_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  spd_pkg::spd_cmd_t                  cmd,
  output spd_pkg::spd_sts_t                  sts,
  input  spd_pkg::spd_hdr_t                  hdr,
  input  logic                               cfg_valid,
  input  logic [spd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spd_pkg::spd_alert_t                alrt
);
  import spd_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [15:0]      thresh;
  logic [31:0]      window;
  spd_hdr_t         hdr_q;
  logic             counted_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] clr_addr;
  spd_entry_t       rd_entry;
  spd_entry_t       entry_q;
  logic             restart_q;
  spd_entry_t       new_entry;
  logic             fire;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_we;
  logic [31:0]      product;
  logic [63:0]      age;
  logic [15:0]      base_count;
  logic [15:0]      base_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
      window <= WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_THRESH: thresh <= cfg_data[15:0];
        CFG_IDX_WINDOW: window <= cfg_data;
        default: ;
      endcase
    end
  end

  assign product = hdr_q.source_addr * HASH_MULT;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hdr_q     <= hdr;
      counted_q <= hdr.is_ipv4 && hdr.is_tcp && hdr.tcp_flag_bits[SYN_BIT];
    end
    if (cmd.hash) begin
      idx_q <= product[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_done = cmd.clear_wr && (clr_addr == {IDX_W{1'b1}});

  assign ram_we    = cmd.clear_wr || (cmd.commit && counted_q);
  assign ram_waddr = cmd.clear_wr ? clr_addr : idx_q;
  assign ram_wdata = cmd.clear_wr ? '0 : new_entry;

  spd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_q),
    .rdata (ram_rdata)
  );

  assign rd_entry = spd_entry_t'(ram_rdata);
  assign age      = hdr_q.time_ms - rd_entry.window_start;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      entry_q   <= rd_entry;
      restart_q <= !rd_entry.valid || (rd_entry.source != hdr_q.source_addr) ||
                   (age > {32'd0, window});
    end
  end

  assign base_count = restart_q ? 16'd0 : entry_q.port_count;
  assign base_last  = restart_q ? 16'd0 : entry_q.prev_port;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      new_entry.valid        <= 1'b1;
      new_entry.source       <= hdr_q.source_addr;
      new_entry.window_start <= restart_q ? hdr_q.time_ms : entry_q.window_start;
      if (hdr_q.dest_port != base_last) begin
        new_entry.port_count <= (base_count == COUNT_MAX) ? base_count : base_count + 16'd1;
        new_entry.prev_port  <= hdr_q.dest_port;
        fire <= counted_q &&
                (((base_count == COUNT_MAX) ? base_count : base_count + 16'd1) == thresh);
      end else begin
        new_entry.port_count <= base_count;
        new_entry.prev_port  <= base_last;
        fire <= counted_q && (base_count == thresh);
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      alrt.alert_fired    <= fire;
      alrt.alert_src_addr <= fire ? hdr_q.source_addr : 32'd0;
      alrt.alert_dst_addr <= fire ? hdr_q.dest_addr : 32'd0;
      alrt.alert_src_port <= fire ? hdr_q.source_port : 16'd0;
      alrt.alert_dst_port <= fire ? hdr_q.dest_port : 16'd0;
      alrt.alert_time_ms  <= fire ? hdr_q.time_ms : 64'd0;
    end
  end

  `ASSERT_CLK(a_no_overwrite, cmd.commit |-> (!out_valid || out_ready), "result overwritten")
  `ASSERT_CLK(a_quiet_fields,
              (out_valid && !alrt.alert_fired) |->
              (alrt.alert_src_addr == 32'd0 && alrt.alert_time_ms == 64'd0),
              "fields set without alert")
  `ASSERT_CLK(a_hold_result, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule

FILE: hw/rtl/syn_port_scan_detector_top.sv
// Sequence: a header beat accepted in idle passes through the hash, read, evaluate and update
// states, and its result beat is registered on commit in the done state; no new header is
// accepted until that write-back to the slot table, and a stalled result holds the next commit.
// Reset: synchronous; config returns to threshold 20 and window 5000 ms, then a clearing
// pass zeroes all TABLE_DEPTH slots of the table while no header is accepted.
// TABLE_DEPTH must be a power of two.
module syn_port_scan_detector_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic      clk,
  input logic      rst,
  spd_pkt_if.sink  pkt,
  spd_alert_if.source alert,
  spd_cfg_if.sink  cfg
);
  import spd_pkg::*;

  spd_cmd_t   cmd;
  spd_sts_t   sts;
  spd_hdr_t   hdr;
  spd_alert_t alrt;

  assign hdr.is_ipv4       = pkt.is_ipv4;
  assign hdr.is_tcp        = pkt.is_tcp;
  assign hdr.tcp_flag_bits = pkt.tcp_flag_bits;
  assign hdr.source_addr   = pkt.source_addr;
  assign hdr.dest_addr     = pkt.dest_addr;
  assign hdr.source_port   = pkt.source_port;
  assign hdr.dest_port     = pkt.dest_port;
  assign hdr.time_ms       = pkt.time_ms;

  assign cfg.ready = 1'b1;

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .in_ready (pkt.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .hdr       (hdr),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (alert.valid),
    .out_ready (alert.ready),
    .alrt      (alrt)
  );

  assign alert.alert_fired    = alrt.alert_fired;
  assign alert.alert_src_addr = alrt.alert_src_addr;
  assign alert.alert_dst_addr = alrt.alert_dst_addr;
  assign alert.alert_src_port = alrt.alert_src_port;
  assign alert.alert_dst_port = alrt.alert_dst_port;
  assign alert.alert_time_ms  = alrt.alert_time_ms;
endmodule

FILE: test/scan_alert_checker.sv
// Checker that predicts every alert beat of the SYN port-scan detector and compares it.
module scan_alert_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  spd_pkt_if          pkt,
  spd_alert_if        alert,
  spd_cfg_if          cfg,
  output int          mismatches,
  output int          alerts_owed,
  output int          alerts_seen
);
  import spd_pkg::*;

  logic        row_live      [TABLE_DEPTH];
  logic [31:0] row_src       [TABLE_DEPTH];
  logic [15:0] row_ports     [TABLE_DEPTH];
  logic [15:0] row_prev_port [TABLE_DEPTH];
  logic [63:0] row_t0        [TABLE_DEPTH];
  logic [15:0] threshold;
  logic [31:0] window;
  spd_alert_t  owed_alerts [$];

  initial begin
    mismatches  = 0;
    alerts_owed = 0;
    alerts_seen = 0;
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    spd_alert_t  want;
    spd_alert_t  got;
    logic [31:0] prod;
    int          row;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) row_live[i] = 1'b0;
      threshold = THRESH_RESET;
      window    = WINDOW_RESET;
      owed_alerts.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_IDX_THRESH: threshold = cfg.data[15:0];
          CFG_IDX_WINDOW: window = cfg.data;
          default: ;
        endcase
      end
      if (alert.valid && alert.ready) begin
        got.alert_fired    = alert.alert_fired;
        got.alert_src_addr = alert.alert_src_addr;
        got.alert_dst_addr = alert.alert_dst_addr;
        got.alert_src_port = alert.alert_src_port;
        got.alert_dst_port = alert.alert_dst_port;
        got.alert_time_ms  = alert.alert_time_ms;
        if (got.alert_fired === 1'b1) alerts_seen++;
        if (owed_alerts.size() == 0) begin
          $error("alert beat with no header waiting for its result");
          mismatches++;
        end else begin
          want = owed_alerts.pop_front();
          compare_field("alert_fired", want.alert_fired, got.alert_fired);
          compare_field("alert_src_addr", want.alert_src_addr, got.alert_src_addr);
          compare_field("alert_dst_addr", want.alert_dst_addr, got.alert_dst_addr);
          compare_field("alert_src_port", want.alert_src_port, got.alert_src_port);
          compare_field("alert_dst_port", want.alert_dst_port, got.alert_dst_port);
          compare_field("alert_time_ms", want.alert_time_ms, got.alert_time_ms);
        end
      end
      if (pkt.valid && pkt.ready) begin
        want = '0;
        if (pkt.is_ipv4 && pkt.is_tcp && pkt.tcp_flag_bits[SYN_BIT]) begin
          prod = pkt.source_addr * HASH_MULT;
          row  = int'(prod % TABLE_DEPTH);
          if (!row_live[row] || row_src[row] != pkt.source_addr ||
              pkt.time_ms - row_t0[row] > {32'd0, window}) begin
            row_live[row]      = 1'b1;
            row_src[row]       = pkt.source_addr;
            row_ports[row]     = '0;
            row_prev_port[row] = '0;
            row_t0[row]        = pkt.time_ms;
          end
          if (pkt.dest_port != row_prev_port[row]) begin
            if (row_ports[row] != COUNT_MAX) row_ports[row]++;
            row_prev_port[row] = pkt.dest_port;
          end
          if (row_ports[row] == threshold) begin
            want.alert_fired    = 1'b1;
            want.alert_src_addr = pkt.source_addr;
            want.alert_dst_addr = pkt.dest_addr;
            want.alert_src_port = pkt.source_port;
            want.alert_dst_port = pkt.dest_port;
            want.alert_time_ms  = pkt.time_ms;
          end
        end
        owed_alerts.push_back(want);
      end
    end
    alerts_owed = owed_alerts.size();
  end

endmodule

FILE: test/syn_port_scan_detector_top_tb.sv
// Testbench top: drives headers, register writes and alert back-pressure, and gives the verdict.
module syn_port_scan_detector_top_tb;
  import spd_pkg::*;

  localparam int         DEPTH            = 1024;
  localparam logic [1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int         PHASE_SYNS       = 200;
  localparam int         BURST_HDRS       = 40;
  localparam int         STALL_LIMIT      = 5000;
  localparam int         DRAIN_CYCLES     = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          idle_pct = 13;
  int          hdrs_sent = 0;
  int          syn_sent = 0;
  int          settings_used = 0;
  int          stall_cycles = 0;
  int          mismatches;
  int          alerts_owed;
  int          alerts_seen;
  logic [63:0] now;
  logic [31:0] src_pool [8];

  spd_pkt_if   pkt ();
  spd_alert_if alert ();
  spd_cfg_if   cfg ();

  syn_port_scan_detector_top #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk   (clk),
    .rst   (rst),
    .pkt   (pkt),
    .alert (alert),
    .cfg   (cfg)
  );

  scan_alert_checker #(.TABLE_DEPTH(DEPTH)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .alert       (alert),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .alerts_owed (alerts_owed),
    .alerts_seen (alerts_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    alert.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((pkt.valid && pkt.ready) || (alert.valid && alert.ready) || (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic spd_hdr_t syn_hdr(input logic [31:0] src, input logic [15:0] dport,
                                       input logic [63:0] stamp);
    spd_hdr_t h;
    h.is_ipv4                = 1'b1;
    h.is_tcp                 = 1'b1;
    h.tcp_flag_bits          = 8'($urandom);
    h.tcp_flag_bits[SYN_BIT] = 1'b1;
    h.source_addr            = src;
    h.dest_addr              = $urandom;
    h.source_port            = 16'($urandom);
    h.dest_port              = dport;
    h.time_ms                = stamp;
    return h;
  endfunction

  task automatic send_hdr(input spd_hdr_t h);
    if ($urandom_range(99) < idle_pct) begin
      pkt.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    pkt.valid         <= 1'b1;
    pkt.is_ipv4       <= h.is_ipv4;
    pkt.is_tcp        <= h.is_tcp;
    pkt.tcp_flag_bits <= h.tcp_flag_bits;
    pkt.source_addr   <= h.source_addr;
    pkt.dest_addr     <= h.dest_addr;
    pkt.source_port   <= h.source_port;
    pkt.dest_port     <= h.dest_port;
    pkt.time_ms       <= h.time_ms;
    @(posedge clk);
    while (!pkt.ready) @(posedge clk);
    hdrs_sent++;
    if (h.is_ipv4 && h.is_tcp && h.tcp_flag_bits[SYN_BIT]) syn_sent++;
  endtask

  // Drop valid in the step of the last beat, then wait for every alert to come back.
  task automatic drain();
    pkt.valid <= 1'b0;
    do @(posedge clk); while (alerts_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [31:0] win);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx[0] = CFG_IDX_THRESH;
    idx[1] = $urandom_range(1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
    idx[2] = CFG_IDX_WINDOW;
    val[0] = {16'($urandom), thr};
    val[1] = $urandom;
    val[2] = win;
    foreach (idx[i]) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data  <= val[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    spd_hdr_t    h;
    logic [31:0] scan_src;
    logic [63:0] t0;
    logic [15:0] thr;
    logic [31:0] win;
    int          target;
    int          roll;
    pkt.valid         = 1'b0;
    pkt.is_ipv4       = 1'b0;
    pkt.is_tcp        = 1'b0;
    pkt.tcp_flag_bits = '0;
    pkt.source_addr   = '0;
    pkt.dest_addr     = '0;
    pkt.source_port   = '0;
    pkt.dest_port     = '0;
    pkt.time_ms       = '0;
    alert.ready       = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = CFG_IDX_THRESH;
    cfg.data          = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // packets that must not be counted, then address and time extremes
    h = syn_hdr(32'h0A00_0001, 16'd80, 64'd0);
    h.is_ipv4 = 1'b0;
    send_hdr(h);
    h = syn_hdr(32'h0A00_0001, 16'd81, 64'd1);
    h.is_tcp = 1'b0;
    send_hdr(h);
    h = syn_hdr(32'h0A00_0001, 16'd82, 64'd2);
    h.tcp_flag_bits = 8'hFF;
    h.tcp_flag_bits[SYN_BIT] = 1'b0;
    send_hdr(h);
    send_hdr(syn_hdr(32'h0000_0000, 16'hFFFF, 64'd0));
    send_hdr(syn_hdr(32'hFFFF_FFFF, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    // port zero after restart, repeats, slot collision, window edge, time going back
    set_regs(16'd3, 32'd100);
    scan_src = $urandom;
    t0 = {$urandom, $urandom};
    send_hdr(syn_hdr(scan_src, 16'd0, t0));
    send_hdr(syn_hdr(scan_src, 16'd1, t0));
    send_hdr(syn_hdr(scan_src, 16'd1, t0));
    send_hdr(syn_hdr(scan_src, 16'd2, t0 + 1));
    send_hdr(syn_hdr(scan_src, 16'd3, t0 + 2));
    send_hdr(syn_hdr(scan_src, 16'd4, t0 + 3));
    send_hdr(syn_hdr(scan_src ^ 32'h0040_0000, 16'd9, t0 + 3));
    send_hdr(syn_hdr(scan_src, 16'd5, t0 + 4));
    send_hdr(syn_hdr(scan_src, 16'd6, t0 + 104));
    send_hdr(syn_hdr(scan_src, 16'd7, t0 + 105));
    send_hdr(syn_hdr(scan_src, 16'd8, t0 + 50));
    drain();

    // zero threshold and the widest window
    set_regs(16'd0, 32'hFFFF_FFFF);
    scan_src = $urandom;
    send_hdr(syn_hdr(scan_src, 16'd0, t0));
    send_hdr(syn_hdr(scan_src, 16'd0, t0 - 1));
    send_hdr(syn_hdr(scan_src, 16'd1, t0 - 1));
    drain();

    // smallest nonzero threshold and a zero window
    set_regs(16'd1, 32'd0);
    send_hdr(syn_hdr(scan_src, 16'd7, t0));
    send_hdr(syn_hdr(scan_src, 16'd8, t0));
    send_hdr(syn_hdr(scan_src, 16'd9, t0 + 1));
    drain();

    // run one source through an alternating-port burst, no idling
    set_regs(16'd32, WINDOW_RESET);
    idle_pct = 0;
    scan_src = $urandom;
    t0 = {$urandom, $urandom};
    for (int i = 0; i < BURST_HDRS; i++)
      send_hdr(syn_hdr(scan_src, i[0] ? 16'h0000 : 16'hFFFF, t0));
    drain();

    idle_pct = 13;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin thr = 16'd1; win = WINDOW_RESET; end
        1: begin thr = 16'd3; win = 32'd50; end
        2: begin thr = 16'd2; win = 32'd0; end
        3: begin thr = 16'd0; win = 32'hFFFF_FFFF; end
        default: begin thr = 16'($urandom_range(2, 8)); win = $urandom_range(1, 300); end
      endcase
      set_regs(thr, win);
      now = {$urandom, $urandom};
      src_pool[0] = $urandom;
      for (int k = 1; k < 8; k++)
        src_pool[k] = (k < 4) ? {22'($urandom), src_pool[0][9:0]} : $urandom;
      target = syn_sent + PHASE_SYNS;
      while (syn_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 75) now = now + $urandom_range(0, 3);
        else if (roll < 85) now = now + $urandom_range(0, 3000);
        else if (roll < 93) now = now - $urandom_range(1, 50);
        else now = {$urandom, $urandom};
        h = syn_hdr(src_pool[$urandom_range(7)], 16'($urandom_range(7)), now);
        if ($urandom_range(9) == 0) h.source_addr = $urandom;
        if ($urandom_range(9) == 0) h.dest_port = 16'($urandom);
        case ($urandom_range(19))
          0: h.is_ipv4 = 1'b0;
          1: h.is_tcp = 1'b0;
          2: h.tcp_flag_bits[SYN_BIT] = 1'b0;
          default: ;
        endcase
        send_hdr(h);
      end
      drain();
    end

    $display("Run covered %0d headers, %0d of them counted SYNs, under %0d register settings.",
             hdrs_sent, syn_sent, settings_used);
    $display("Alert beats with the alert raised: %0d, a back-to-back burst among them.",
             alerts_seen);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
